// ===== hw/rtl/lss_pkg.sv =====
// lss_pkg: shared types and constants for the line substring search unit
// item structs for both channels, register indexes, default parameter values
// no dependencies
`timescale 1ns / 1ps

package lss_pkg;

    // default parameter values
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed widths
    localparam int PAT_LEN_W      = 5;
    localparam int PAT_BYTES_MAX  = 16;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;
    localparam int OUT_OFFSET_W   = 32;
    localparam int HITS_W         = 16;

    localparam logic [7:0]        NEWLINE_BYTE = 8'h0A;
    localparam logic [HITS_W-1:0] HITS_LIMIT   = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [OUT_OFFSET_W-1:0] line_begin;
        logic [OUT_OFFSET_W-1:0] line_finish;
        logic [HITS_W-1:0]       hit_count;
        logic                    final_line;
    } out_item_t;

endpackage

// ===== hw/rtl/line_substring_search_unit.sv =====
// line_substring_search_unit: fixed-string line matcher over a byte stream
// depends on lss_pkg for item types, register indexes and defaults
`timescale 1ns / 1ps

// The unit takes one byte of a text slice per cycle while s_ready is high and
// counts non-overlapping occurrences of a configured pattern of 1 to
// PATTERN_MAX bytes within each line; a newline or the slice's last byte ends
// a line, and a line with at least one hit gives one result item with its
// start offset, its exclusive end offset, the saturating hit count and whether
// it closed the slice. A byte's result, if any, is registered into the output
// register, or into the skid register while the output stalls; the rate is set
// by the combinational window compare and state update. The two-entry output
// buffer lets input items flow on while a result waits; s_ready drops only once
// both entries are full. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wr_data; the user must do so while the unit idles; nothing enforces it.
module line_substring_search_unit
    import lss_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);

    // configuration registers
    logic [PAT_LEN_W-1:0]  pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;

    // stream state
    logic [7:0]             window_reg [PATTERN_MAX];
    logic [7:0]             window_next [PATTERN_MAX];
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [HITS_W-1:0]      hits_reg, hits_next;

    // output buffer
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    logic                   accept;
    logic                   produce;
    out_item_t              result;
    logic [PAT_LEN_W-1:0]   act_len;
    logic [7:0]             pat_bytes [PAT_BYTES_MAX];
    logic [FILL_W-1:0]      fill_shift;
    logic                   window_hit;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [HITS_W-1:0]      hits_upd;
    logic [63:0]            begin_ext, off_ext, off_inc_ext;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= PAT_LEN_W'(1);
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wr_data[PAT_LEN_W-1:0];
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wr_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // active pattern length, clamped to 1..PATTERN_MAX
    always_comb begin
        if (pattern_length_reg == '0) begin
            act_len = PAT_LEN_W'(1);
        end else if (pattern_length_reg > PAT_LEN_W'(PATTERN_MAX)) begin
            act_len = PAT_LEN_W'(PATTERN_MAX);
        end else begin
            act_len = pattern_length_reg;
        end
    end

    // pattern bytes, byte 0 in the low bits of the low word
    always_comb begin
        for (int i = 0; i < PAT_BYTES_MAX / 2; i++) begin
            pat_bytes[i]                     = pattern_low_reg[8*i +: 8];
            pat_bytes[i + PAT_BYTES_MAX / 2] = pattern_high_reg[8*i +: 8];
        end
    end

    // window shift, entry 0 is the newest byte
    always_comb begin
        window_next[0] = s_item.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    assign fill_shift = (fill_reg == FILL_W'(PATTERN_MAX)) ? fill_reg : fill_reg + 1'b1;

    // parallel compare: window entry k against pattern byte len-1-k
    always_comb begin
        logic [PAT_LEN_W-1:0] idx;
        window_hit = (PAT_LEN_W'(fill_shift) >= act_len);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            idx = act_len - PAT_LEN_W'(1) - PAT_LEN_W'(k);
            if (PAT_LEN_W'(k) < act_len) begin
                if (window_next[k] != pat_bytes[idx[3:0]]) begin
                    window_hit = 1'b0;
                end
            end
        end
    end

    assign off_inc     = offset_reg + 1'b1;
    assign hits_upd    = (hits_reg == HITS_LIMIT) ? hits_reg : hits_reg + 1'b1;
    assign begin_ext   = 64'(begin_reg);
    assign off_ext     = 64'(offset_reg);
    assign off_inc_ext = 64'(off_inc);

    // per-byte state update and result
    always_comb begin
        fill_next          = fill_reg;
        hits_next          = hits_reg;
        begin_next         = begin_reg;
        offset_next        = offset_reg;
        produce            = 1'b0;
        result.line_begin  = begin_ext[OUT_OFFSET_W-1:0];
        result.line_finish = off_inc_ext[OUT_OFFSET_W-1:0];
        result.hit_count   = hits_reg;
        result.final_line  = s_item.last_byte;
        if (s_item.data_byte == NEWLINE_BYTE) begin
            produce            = (hits_reg != '0);
            result.line_finish = off_ext[OUT_OFFSET_W-1:0];
            fill_next          = '0;
            hits_next          = '0;
            begin_next         = off_inc;
        end else begin
            if (window_hit) begin
                hits_next = hits_upd;
                fill_next = '0;
            end else begin
                fill_next = fill_shift;
            end
            result.hit_count = hits_next;
            produce          = s_item.last_byte && (hits_next != '0);
        end
        if (s_item.last_byte) begin
            fill_next   = '0;
            hits_next   = '0;
            offset_next = '0;
            begin_next  = '0;
        end else begin
            offset_next = off_inc;
        end
    end

    // stream state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            hits_reg   <= '0;
            offset_reg <= '0;
            begin_reg  <= '0;
        end else if (accept) begin
            fill_reg   <= fill_next;
            hits_reg   <= hits_next;
            offset_reg <= offset_next;
            begin_reg  <= begin_next;
        end
    end

    // window bytes, only read behind the fill count
    always_ff @(posedge aclk) begin
        if (accept && s_item.data_byte != NEWLINE_BYTE) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    // output register and skid entry
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !m_ready) begin
            if (accept && produce) begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else if (accept && produce) begin
            out_next       = result;
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
